// ===== rtl/tpps_pkg.sv =====
package tpps_pkg;

   localparam int SIZE_W  = 16;
   localparam int TIME_W  = 48;
   localparam int UNIT_W  = 48;
   localparam int FRAC_W  = 24;
   localparam int COUNT_W = SIZE_W + 1;
   localparam int PROD_W  = COUNT_W + UNIT_W;
   localparam int SPAN_W  = PROD_W - FRAC_W;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 104;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_RATE_MODE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_INTERVAL = 1'd1;

   localparam logic MODE_BYTE   = 1'b0;
   localparam logic MODE_PACKET = 1'b1;

   // one admitted transaction, sized and ready for the timing stage
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  now_us;
      logic               last_valid;
      logic               older_valid;
   } item_type;

   typedef struct packed {
      logic              send_now;
      logic [TIME_W-1:0] delay_us;
      logic [TIME_W-1:0] send_time_us;
   } result_type;

endpackage

// ===== rtl/two_packet_pacing_shaper_top.sv =====
// channel | dir | handshake           | payload
// req     | in  | req_tvalid/tready   | tdata: packet_size, now_us
// rsp     | out | rsp_tvalid/tready   | tdata: send_now, delay_us, send_time_us
// csr     | in  | csr_we (no ready)   | csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp is not stalled; req reaches rsp
// through the admit register, then the target register that holds the result.
// The multiply, window add, clamp and compare run combinationally between the
// admit register and the result register; the send-time history closes there.
// Synchronous active-high reset clears history, valid flags and CSR registers; item and result data are not reset.
// A stalled rsp holds its result while one more req waits in the admit stage.
module two_packet_pacing_shaper_top
   import tpps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // packet_size[15:0], now_us[63:16]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // send_now[0], delay_us[48:1],
                                               // send_time_us[96:49], zero [103:97]
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [UNIT_W-1:0]      csr_wdata
);

   logic              rate_mode_ff, rate_mode_in;
   logic [UNIT_W-1:0] unit_ff, unit_in;
   logic              item_valid;
   logic              item_take;
   item_type          item;
   result_type        result;

   always_comb begin
      rate_mode_in = rate_mode_ff;
      unit_in      = unit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RATE_MODE:     rate_mode_in = csr_wdata[0];
            CSR_UNIT_INTERVAL: unit_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_mode_ff <= MODE_BYTE;
         unit_ff      <= '0;
      end else begin
         rate_mode_ff <= rate_mode_in;
         unit_ff      <= unit_in;
      end
   end

   tpps_admit u_admit (
      .clock       (clock),
      .reset       (reset),
      .rate_mode   (rate_mode_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .packet_size (req_tdata[SIZE_W-1:0]),
      .now_us      (req_tdata[SIZE_W+TIME_W-1:SIZE_W]),
      .item_valid  (item_valid),
      .item_take   (item_take),
      .item        (item)
   );

   tpps_target u_target (
      .clock         (clock),
      .reset         (reset),
      .unit_interval (unit_ff),
      .item_valid    (item_valid),
      .item_take     (item_take),
      .item          (item),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .result        (result)
   );

   assign rsp_tdata = {{(RSP_DATA_W-1-2*TIME_W){1'b0}},
                       result.send_time_us, result.delay_us, result.send_now};

endmodule

// ===== rtl/tpps_admit.sv =====
module tpps_admit
   import tpps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rate_mode,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [SIZE_W-1:0]   packet_size,
   input  logic [TIME_W-1:0]   now_us,
   output logic                item_valid,
   input  logic                item_take,
   output item_type            item
);

   logic               item_vld_ff, item_vld_in;
   item_type           item_ff, item_in;
   logic               seen1_ff, seen1_in;
   logic               seen2_ff, seen2_in;
   logic [SIZE_W-1:0]  last_size_ff, last_size_in;
   logic               accept;

   assign in_ready = !item_vld_ff || item_take;
   assign accept   = in_valid && in_ready;

   always_comb begin
      item_in.now_us      = now_us;
      item_in.last_valid  = seen1_ff;
      item_in.older_valid = seen2_ff;
      // span length: two-packet window once two earlier packets exist
      if (rate_mode == MODE_PACKET) begin
         item_in.count = seen2_ff ? COUNT_W'(2) : COUNT_W'(1);
      end else begin
         item_in.count = seen2_ff ? ({1'b0, packet_size} + {1'b0, last_size_ff})
                                  : {1'b0, packet_size};
      end
      item_vld_in  = accept ? 1'b1 : (item_take ? 1'b0 : item_vld_ff);
      seen1_in     = accept ? 1'b1 : seen1_ff;
      seen2_in     = accept ? seen1_ff : seen2_ff;
      last_size_in = accept ? packet_size : last_size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff  <= 1'b0;
         seen1_ff     <= 1'b0;
         seen2_ff     <= 1'b0;
         last_size_ff <= '0;
      end else begin
         item_vld_ff  <= item_vld_in;
         seen1_ff     <= seen1_in;
         seen2_ff     <= seen2_in;
         last_size_ff <= last_size_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = item_vld_ff;
   assign item       = item_ff;

   a_older_needs_last: assert property (@(posedge clock) disable iff (reset)
      item_vld_ff && item_ff.older_valid |-> item_ff.last_valid)
      else $error("older packet flagged without a last packet");

   a_seen_order: assert property (@(posedge clock) disable iff (reset)
      seen2_ff |-> seen1_ff)
      else $error("history count out of order");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      item_vld_ff && !item_take |=> item_vld_ff && $stable(item_ff))
      else $error("stalled item changed");

endmodule

// ===== rtl/tpps_target.sv =====
module tpps_target
   import tpps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [UNIT_W-1:0]   unit_interval,
   input  logic                item_valid,
   output logic                item_take,
   input  item_type            item,
   output logic                out_valid,
   input  logic                out_ready,
   output result_type          result
);

   logic [TIME_W-1:0] last_send_ff, last_send_in;
   logic [TIME_W-1:0] older_send_ff, older_send_in;
   logic              out_vld_ff, out_vld_in;
   result_type        result_ff, result_in;
   logic [PROD_W-1:0] product;
   logic [SPAN_W-1:0] span;
   logic [TIME_W-1:0] ref_time;
   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] target;

   assign item_take = item_valid && (!out_vld_ff || out_ready);

   always_comb begin
      product  = PROD_W'(item.count) * PROD_W'(unit_interval);
      span     = product[PROD_W-1:FRAC_W];
      ref_time = item.older_valid ? older_send_ff : last_send_ff;
      sum      = {1'b0, ref_time} + (TIME_W+1)'(span);
      // clamp to the top of the time counter
      target   = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

      result_in.send_now     = 1'b1;
      result_in.delay_us     = '0;
      result_in.send_time_us = item.now_us;
      if (item.last_valid && (target > item.now_us)) begin
         result_in.send_now     = 1'b0;
         result_in.delay_us     = target - item.now_us;
         result_in.send_time_us = target;
      end

      out_vld_in    = item_take ? 1'b1 : (out_ready ? 1'b0 : out_vld_ff);
      older_send_in = item_take ? last_send_ff : older_send_ff;
      last_send_in  = item_take ? result_in.send_time_us : last_send_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff    <= 1'b0;
         last_send_ff  <= '0;
         older_send_ff <= '0;
      end else begin
         out_vld_ff    <= out_vld_in;
         last_send_ff  <= last_send_in;
         older_send_ff <= older_send_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         result_ff <= result_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign result    = result_ff;

   a_now_means_no_delay: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && result_ff.send_now |-> result_ff.delay_us == '0)
      else $error("immediate send with nonzero delay");

   a_wait_means_delay: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !result_ff.send_now |-> result_ff.delay_us != '0)
      else $error("held packet with zero delay");

   a_history_tracks_result: assert property (@(posedge clock) disable iff (reset)
      $past(item_take && !reset) |-> last_send_ff == result_ff.send_time_us)
      else $error("send time history out of step with result");

endmodule
